FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Constants and controller/datapath interface types for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

  localparam int RCFP_BUF_BYTES = 8;
  localparam int BYTE_W         = 8;
  localparam int LEN_W          = 4;
  localparam int VAL_W          = 32;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] COLLIDE_BYTE  = 8'hFC;
  localparam logic [BYTE_W-1:0] END_BYTE      = 8'hFD;

  localparam logic [3:0] DIGIT_LIMIT = 4'hA;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_count;
    logic load_dest;
    logic load_src;
    logic load_cmd;
    logic store_byte;
    logic dec_start;
    logic dec_step;
    logic load_out;
  } rcfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_preamble;
    logic is_collide;
    logic is_end;
    logic buf_full;
    logic dec_done;
    logic out_free;
  } rcfp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rcfp_ctrl.sv
// ----------------------------------------------------------------------------
// rcfp_ctrl
// Frame parse controller: tracks the frame phase, sequences the BCD decode
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_ctrl
  import rcfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rcfp_stat_t stat,
  output rcfp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_HUNT1,
    ST_HUNT2,
    ST_DEST,
    ST_SRC,
    ST_CMD,
    ST_PAYLOAD,
    ST_DECODE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r != ST_DECODE) && (state_r != ST_EMIT);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HUNT1: begin
        if (in_fire && stat.is_preamble) begin
          cmd.clear_count = 1'b1;
          state_nxt       = ST_HUNT2;
        end
      end
      ST_HUNT2: begin
        if (in_fire) begin
          state_nxt = stat.is_preamble ? ST_DEST : ST_HUNT1;
        end
      end
      ST_DEST: begin
        if (in_fire) begin
          if (stat.is_collide) begin
            state_nxt = ST_HUNT1;
          end else begin
            cmd.load_dest = 1'b1;
            state_nxt     = ST_SRC;
          end
        end
      end
      ST_SRC: begin
        if (in_fire) begin
          if (stat.is_collide) begin
            state_nxt = ST_HUNT1;
          end else begin
            cmd.load_src = 1'b1;
            state_nxt    = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (in_fire) begin
          if (stat.is_collide) begin
            state_nxt = ST_HUNT1;
          end else begin
            cmd.load_cmd = 1'b1;
            state_nxt    = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_fire) begin
          if (stat.is_collide) begin
            state_nxt = ST_HUNT1;
          end else if (stat.is_end) begin
            cmd.dec_start = 1'b1;
            state_nxt     = ST_DECODE;
          end else if (!stat.buf_full) begin
            cmd.store_byte = 1'b1;
          end else begin
            state_nxt = ST_HUNT1;
          end
        end
      end
      ST_DECODE: begin
        cmd.dec_step = 1'b1;
        if (stat.dec_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_HUNT1;
        end
      end
      default: begin
        state_nxt = ST_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rcfp_dp.sv
// ----------------------------------------------------------------------------
// rcfp_dp
// Frame parser datapath: header registers, payload store, iterative BCD
// decoder and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_dp
  import rcfp_pkg::*;
#(
  parameter int BUF_BYTES = RCFP_BUF_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire rcfp_cmd_t         cmd,
  output rcfp_stat_t             stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_dest_addr,
  output logic [BYTE_W-1:0]      out_src_addr,
  output logic [BYTE_W-1:0]      out_command_code,
  output logic [LEN_W-1:0]       out_payload_len,
  output logic [VAL_W-1:0]       out_decoded_value,
  output logic                   out_digits_ok
);

  localparam int IDX_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_BYTES);

  logic [BYTE_W-1:0] dest_r, src_r, command_r;
  logic [LEN_W-1:0]  count_r;
  logic [BYTE_W-1:0] store_r [BUF_BYTES];

  logic [LEN_W-1:0]  idx_r;
  logic [VAL_W-1:0]  acc_r;
  logic              ok_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_dest_r, out_src_r, out_command_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_ok_r;

  logic [LEN_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] rd_byte;
  logic [3:0]        dig_hi, dig_lo;
  logic              dig_bad;
  logic [6:0]        pair_val;
  logic [VAL_W-1:0]  acc_nxt;

  // The decode walks from the last stored byte down to the first one.
  assign rd_pos   = idx_r - LEN_W'(1);
  assign rd_byte  = store_r[rd_pos[IDX_W-1:0]];
  assign dig_hi   = rd_byte[7:4];
  assign dig_lo   = rd_byte[3:0];
  assign dig_bad  = (dig_hi >= DIGIT_LIMIT) || (dig_lo >= DIGIT_LIMIT);
  assign pair_val = 7'(dig_hi) * 7'd10 + 7'(dig_lo);
  assign acc_nxt  = VAL_W'(acc_r * VAL_W'(100)) + VAL_W'(pair_val);

  always_comb begin
    stat.is_preamble = (in_rx_byte == PREAMBLE_BYTE);
    stat.is_collide  = (in_rx_byte == COLLIDE_BYTE);
    stat.is_end      = (in_rx_byte == END_BYTE);
    stat.buf_full    = (count_r >= BUF_LIMIT);
    stat.dec_done    = (idx_r == '0) || dig_bad;
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r    <= '0;
      src_r     <= '0;
      command_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.load_dest) dest_r <= in_rx_byte;
      if (cmd.load_src)  src_r <= in_rx_byte;
      if (cmd.load_cmd)  command_r <= in_rx_byte;
      if (cmd.clear_count) begin
        count_r <= '0;
      end else if (cmd.store_byte) begin
        count_r <= count_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      store_r[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_start) begin
      idx_r <= count_r;
      acc_r <= '0;
      ok_r  <= 1'b1;
    end else if (cmd.dec_step && (idx_r != '0)) begin
      if (dig_bad) begin
        idx_r <= '0;
        acc_r <= '0;
        ok_r  <= 1'b0;
      end else begin
        idx_r <= rd_pos;
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dest_r    <= dest_r;
      out_src_r     <= src_r;
      out_command_r <= command_r;
      out_len_r     <= count_r;
      out_value_r   <= acc_r;
      out_ok_r      <= ok_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_addr     = out_dest_r;
  assign out_src_addr      = out_src_r;
  assign out_command_code  = out_command_r;
  assign out_payload_len   = out_len_r;
  assign out_decoded_value = out_value_r;
  assign out_digits_ok     = out_ok_r;

endmodule

`default_nettype wire

FILE: rtl/core/radio_control_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// radio_control_frame_parser_unit
// Parses preamble-delimited control frames byte by byte and reports each
// completed frame with its payload decoded as little-endian packed BCD.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Word
//  in_      input      in_valid / in_ready   in_rx_byte
//  out_     output     out_valid / out_ready dest, src, command, len, value, ok
//
//  Bytes are taken while in_ready is high, a frame end byte included.
//  An end byte starts the BCD decode: one stored byte per cycle, from the
//  last stored byte down (it stops at the first non-decimal digit); the
//  result then loads into the output register once that is free.
//  in_ready stays low during decode and while the result waits for a free
//  output register; bytes are otherwise taken while a result waits.
//  Synchronous active-low reset returns the parser to preamble hunting.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_control_frame_parser_unit
  import rcfp_pkg::*;
#(
  parameter int BUF_BYTES = RCFP_BUF_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_dest_addr,
  output logic [BYTE_W-1:0]      out_src_addr,
  output logic [BYTE_W-1:0]      out_command_code,
  output logic [LEN_W-1:0]       out_payload_len,
  output logic [VAL_W-1:0]       out_decoded_value,
  output logic                   out_digits_ok
);

  rcfp_cmd_t  cmd;
  rcfp_stat_t stat;

  rcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcfp_dp #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_dest_addr     (out_dest_addr),
    .out_src_addr      (out_src_addr),
    .out_command_code  (out_command_code),
    .out_payload_len   (out_payload_len),
    .out_decoded_value (out_decoded_value),
    .out_digits_ok     (out_digits_ok)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rcfp_checker.sv
// ----------------------------------------------------------------------------
// rcfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcfp_checker
  import rcfp_pkg::*;
#(
  parameter int BUF_BYTES = RCFP_BUF_BYTES
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [BYTE_W-1:0] in_rx_byte,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_dest_addr,
  input wire logic [BYTE_W-1:0] out_src_addr,
  input wire logic [BYTE_W-1:0] out_command_code,
  input wire logic [LEN_W-1:0]  out_payload_len,
  input wire logic [VAL_W-1:0]  out_decoded_value,
  input wire logic              out_digits_ok
);

  localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_BYTES);
  localparam int OUT_W = 3 * BYTE_W + LEN_W + VAL_W + 1;

  logic             in_fire;
  logic [OUT_W-1:0] out_word;

  assign in_fire  = in_valid && in_ready;
  assign out_word = {out_dest_addr, out_src_addr, out_command_code,
                     out_payload_len, out_decoded_value, out_digits_ok};

  // A stalled result word holds.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

  // A waiting input word holds until it is taken.
  `ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_rx_byte))

  // A rejected decode always reports zero.
  `ASSERT_IMP(a_bad_digits_zero, clk, rst_n, out_valid && !out_digits_ok, out_decoded_value == '0)

  // The stored payload never exceeds the buffer.
  `ASSERT_IMP(a_len_bound, clk, rst_n, out_valid, out_payload_len <= BUF_LIMIT)

  // A new result is loaded only after the decode, when no byte is taken.
  `ASSERT_IMP(a_emit_after_decode, clk, rst_n, $rose(out_valid), !$past(in_fire))

endmodule

bind radio_control_frame_parser_unit rcfp_checker #(
  .BUF_BYTES (BUF_BYTES)
) u_rcfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_dest_addr     (out_dest_addr),
  .out_src_addr      (out_src_addr),
  .out_command_code  (out_command_code),
  .out_payload_len   (out_payload_len),
  .out_decoded_value (out_decoded_value),
  .out_digits_ok     (out_digits_ok)
);

`default_nettype wire
